@@ rtl/bpc_pkg.sv @@
// Shared widths, register codes and types of the barometric pressure compensation block.
package bpc_pkg;

  localparam int RAW_W     = 24;
  localparam int FRAC_W    = 24;
  localparam int P_W       = 31;
  localparam int Q_MW      = 30;
  localparam int RECIP_W   = 31;
  localparam int DIV_W     = 23;
  localparam int NMD_W     = RAW_W + FRAC_W + 1;
  localparam int CMP_W     = Q_MW + DIV_W + 1;
  localparam int CL_W      = 20;
  localparam int CS_W      = 16;
  localparam int A_W       = CS_W + P_W;
  localparam int B_W       = P_W + A_W - FRAC_W;
  localparam int TP_W      = P_W + P_W - FRAC_W;
  localparam int PP_W      = P_W + B_W - FRAC_W;
  localparam int TPD_W     = TP_W + A_W - FRAC_W;
  localparam int TOT_W     = PP_W + 1;
  localparam int OUT_SHIFT = 18;
  localparam int RND_W     = TOT_W - OUT_SHIFT;
  localparam int OUT_W     = 32;
  localparam int CFG_W     = CL_W;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_OFFSET = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_P1     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_P2     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_P3     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_T1     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_TP1    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_TP2    = 3'd6;

  localparam logic [RAW_W-1:0] RAW_REJECT = 24'h800000;

  localparam int SCALE_LAT = 5;
  localparam int POLY_LAT  = 13;
  localparam int LAT       = SCALE_LAT + POLY_LAT + 1;

  typedef struct packed {
    logic signed [CL_W-1:0] offset;
    logic signed [CL_W-1:0] p1;
    logic signed [CS_W-1:0] p2;
    logic signed [CS_W-1:0] p3;
    logic signed [CS_W-1:0] t1;
    logic signed [CS_W-1:0] tp1;
    logic signed [CS_W-1:0] tp2;
  } bpc_coef_t;

endpackage

@@ rtl/bpc_scale.sv @@
// Pipelined scaling of a raw reading into Q7.24 by a constant divisor with rounding.
module bpc_scale
  import bpc_pkg::*;
#(
  parameter int DIVISOR = 253952
) (
  input  logic                    clk,
  input  logic signed [RAW_W-1:0] raw,
  output logic signed [P_W-1:0]   q
);

  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << (2 * FRAC_W)) / DIVISOR);
  localparam logic [DIV_W-1:0] DIV_C = DIV_W'(DIVISOR);
  localparam logic signed [NMD_W-1:0] CORR = NMD_W'(DIVISOR - DIVISOR / 2);

  logic [RAW_W-1:0]           mag_r, mag_nxt;
  logic [3:0]                 neg_r;
  logic [RAW_W+RECIP_W-1:0]   quo_r, quo_nxt;
  logic signed [NMD_W-1:0]    nmd_r, nmd_nxt, nmd3_r;
  logic [Q_MW-1:0]            q0_r;
  logic [Q_MW+DIV_W-1:0]      q0d_r, q0d_nxt;
  logic [Q_MW-1:0]            qc_r, qc_nxt;
  logic signed [P_W-1:0]      q_r, q_nxt;
  logic                       ge;

  always_comb begin
    mag_nxt = raw[RAW_W-1] ? RAW_W'(-raw) : RAW_W'(raw);
    quo_nxt = mag_r * RECIP;
    nmd_nxt = $signed({1'b0, mag_r, {FRAC_W{1'b0}}}) - CORR;
    q0d_nxt = quo_r[FRAC_W +: Q_MW] * DIV_C;
    ge      = ($signed({1'b0, q0d_r}) <= CMP_W'(nmd3_r));
    qc_nxt  = q0_r + Q_MW'(ge);
    q_nxt   = neg_r[3] ? -$signed({1'b0, qc_r}) : $signed({1'b0, qc_r});
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    neg_r  <= {neg_r[2:0], raw[RAW_W-1]};
    quo_r  <= quo_nxt;
    nmd_r  <= nmd_nxt;
    q0_r   <= quo_r[FRAC_W +: Q_MW];
    q0d_r  <= q0d_nxt;
    nmd3_r <= nmd_r;
    qc_r   <= qc_nxt;
    q_r    <= q_nxt;
  end

  assign q = q_r;

endmodule

@@ rtl/bpc_mulq.sv @@
// Four-stage Q.24 multiplier from split partial products, rounded with ties away from zero.
module bpc_mulq
  import bpc_pkg::*;
#(
  parameter int XW = 31,
  parameter int YW = 31
) (
  input  logic                           clk,
  input  logic signed [XW-1:0]           x,
  input  logic signed [YW-1:0]           y,
  output logic signed [XW+YW-FRAC_W-1:0] prod
);

  localparam int XL  = XW / 2;
  localparam int YL  = YW / 2;
  localparam int PW  = XW + YW;
  localparam int LLW = XL + YL;
  localparam int LHW = XL + 1 + YW - YL;
  localparam int HLW = XW - XL + YL + 1;
  localparam int HHW = PW - LLW;
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FRAC_W - 1);

  logic [XL-1:0]              xl;
  logic signed [XW-XL-1:0]    xh;
  logic [YL-1:0]              yl;
  logic signed [YW-YL-1:0]    yh;
  logic [LLW-1:0]             ll_r, ll_nxt;
  logic signed [LHW-1:0]      lh_r, lh_nxt;
  logic signed [HLW-1:0]      hl_r, hl_nxt;
  logic signed [HHW-1:0]      hh_r, hh_nxt;
  logic signed [PW-1:0]       cat_r, cat_nxt, mid_r, mid_nxt, full_r, full_nxt;
  logic [PW-1:0]              rsum;
  logic signed [PW-FRAC_W-1:0] prod_r, prod_nxt;

  assign xl = x[XL-1:0];
  assign xh = x[XW-1:XL];
  assign yl = y[YL-1:0];
  assign yh = y[YW-1:YL];

  always_comb begin
    ll_nxt   = xl * yl;
    lh_nxt   = $signed({1'b0, xl}) * yh;
    hl_nxt   = xh * $signed({1'b0, yl});
    hh_nxt   = xh * yh;
    cat_nxt  = $signed({hh_r, ll_r});
    mid_nxt  = (PW'(lh_r) <<< YL) + (PW'(hl_r) <<< XL);
    full_nxt = cat_r + mid_r;
    rsum     = full_r + HALF - PW'(full_r[PW-1]);
    prod_nxt = rsum[PW-1:FRAC_W];
  end

  always_ff @(posedge clk) begin
    ll_r   <= ll_nxt;
    lh_r   <= lh_nxt;
    hl_r   <= hl_nxt;
    hh_r   <= hh_nxt;
    cat_r  <= cat_nxt;
    mid_r  <= mid_nxt;
    full_r <= full_nxt;
    prod_r <= prod_nxt;
  end

  assign prod = prod_r;

endmodule

@@ rtl/bpc_poly.sv @@
// Pipelined Horner evaluation of the calibration polynomial and final rounding to 1/64 Pa.
module bpc_poly
  import bpc_pkg::*;
(
  input  logic                    clk,
  input  bpc_coef_t               coef,
  input  logic signed [P_W-1:0]   p,
  input  logic signed [P_W-1:0]   t,
  output logic signed [RND_W-1:0] rnd
);

  localparam logic signed [TOT_W-1:0] HALF = TOT_W'(1) <<< (OUT_SHIFT - 1);

  logic signed [A_W-1:0]   c30p_r, c30p_nxt, c21p_r, c21p_nxt, ct_nxt;
  logic signed [A_W-1:0]   a_r, a_nxt, d_nxt;
  logic signed [A_W-1:0]   d_d_r [2:4];
  logic signed [A_W-1:0]   ct_d_r [1:8];
  logic signed [P_W-1:0]   p_d_r [1:7];
  logic signed [TP_W-1:0]  tp;
  logic signed [B_W-1:0]   pa, b_r, b_nxt;
  logic signed [PP_W-1:0]  pp;
  logic signed [TPD_W-1:0] tpd;
  logic signed [TOT_W-1:0] s1_r, s1_nxt, s2_r, s2_nxt, s3_r, tot_r, tot_nxt;
  logic [TOT_W-1:0]        rsum;
  logic signed [RND_W-1:0] rnd_r, rnd_nxt;

  always_comb begin
    c30p_nxt = $signed(coef.p3) * p;
    c21p_nxt = $signed(coef.tp2) * p;
    ct_nxt   = $signed(coef.t1) * t;
    a_nxt    = c30p_r + (A_W'($signed(coef.p2)) <<< FRAC_W);
    d_nxt    = c21p_r + (A_W'($signed(coef.tp1)) <<< FRAC_W);
    b_nxt    = pa + (B_W'($signed(coef.p1)) <<< FRAC_W);
    s1_nxt   = TOT_W'(tpd) + TOT_W'(ct_d_r[8]);
    s2_nxt   = s1_r + (TOT_W'($signed(coef.offset)) <<< FRAC_W);
    tot_nxt  = TOT_W'(pp) + s3_r;
    rsum     = tot_r + HALF - TOT_W'(tot_r[TOT_W-1]);
    rnd_nxt  = rsum[TOT_W-1:OUT_SHIFT];
  end

  always_ff @(posedge clk) begin
    c30p_r    <= c30p_nxt;
    c21p_r    <= c21p_nxt;
    a_r       <= a_nxt;
    d_d_r[2]  <= d_nxt;
    d_d_r[3]  <= d_d_r[2];
    d_d_r[4]  <= d_d_r[3];
    ct_d_r[1] <= ct_nxt;
    for (int i = 2; i <= 8; i++) begin
      ct_d_r[i] <= ct_d_r[i-1];
    end
    p_d_r[1] <= p;
    for (int i = 2; i <= 7; i++) begin
      p_d_r[i] <= p_d_r[i-1];
    end
    b_r   <= b_nxt;
    s1_r  <= s1_nxt;
    s2_r  <= s2_nxt;
    s3_r  <= s2_r;
    tot_r <= tot_nxt;
    rnd_r <= rnd_nxt;
  end

  bpc_mulq #(.XW(P_W), .YW(P_W)) u_mul_tp (
    .clk  (clk),
    .x    (t),
    .y    (p),
    .prod (tp)
  );

  bpc_mulq #(.XW(P_W), .YW(A_W)) u_mul_pa (
    .clk  (clk),
    .x    (p_d_r[2]),
    .y    (a_r),
    .prod (pa)
  );

  bpc_mulq #(.XW(TP_W), .YW(A_W)) u_mul_tpd (
    .clk  (clk),
    .x    (tp),
    .y    (d_d_r[4]),
    .prod (tpd)
  );

  bpc_mulq #(.XW(P_W), .YW(B_W)) u_mul_pp (
    .clk  (clk),
    .x    (p_d_r[7]),
    .y    (b_r),
    .prod (pp)
  );

  assign rnd = rnd_r;

endmodule

@@ rtl/baro_pressure_compensation.sv @@
// Top level of the barometric pressure compensation pipeline with its coefficient registers.
//
// Channel  Ports                                           Transfer at rising edge when
// input    start, busy, in_raw_pressure, in_raw_temperature  start && !busy
// result   out_strobe, out_pressure_fx, out_valid_res      out_strobe (one cycle each)
// config   cfg_we, cfg_index, cfg_data                     cfg_we
//
// One reading is taken every cycle. Each result passes through the 5-stage reciprocal
// scaler, the 13-stage Horner multiplier chain and the output register. busy stays low,
// and results leave in transfer order. The receiver cannot stall. Synchronous reset
// clears the coefficients and the valid pipeline, so readings in flight at reset are
// dropped.
module baro_pressure_compensation
  import bpc_pkg::*;
#(
  parameter int PRESSURE_SCALE = 253952,
  parameter int TEMP_SCALE     = 1572864
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [RAW_W-1:0] in_raw_pressure,
  input  logic signed [RAW_W-1:0] in_raw_temperature,
  output logic                    out_strobe,
  output logic signed [OUT_W-1:0] out_pressure_fx,
  output logic                    out_valid_res,
  input  logic                    cfg_we,
  input  logic [REG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  bpc_coef_t               coef_r, coef_nxt;
  logic [LAT-1:0]          vld_r, vld_nxt;
  logic [LAT-2:0]          rej_r, rej_nxt;
  logic signed [OUT_W-1:0] fx_r, fx_nxt;
  logic                    ok_r, ok_nxt;
  logic                    accept, reject;
  logic signed [P_W-1:0]   p_q24, t_q24;
  logic signed [RND_W-1:0] rnd;
  logic [RND_W-OUT_W:0]    rnd_hi;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign reject = (in_raw_pressure == '0) || (in_raw_pressure == RAW_REJECT);

  always_comb begin
    coef_nxt = coef_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_OFFSET: coef_nxt.offset = cfg_data[CL_W-1:0];
        REG_P1:     coef_nxt.p1     = cfg_data[CL_W-1:0];
        REG_P2:     coef_nxt.p2     = cfg_data[CS_W-1:0];
        REG_P3:     coef_nxt.p3     = cfg_data[CS_W-1:0];
        REG_T1:     coef_nxt.t1     = cfg_data[CS_W-1:0];
        REG_TP1:    coef_nxt.tp1    = cfg_data[CS_W-1:0];
        REG_TP2:    coef_nxt.tp2    = cfg_data[CS_W-1:0];
        default:    coef_nxt        = coef_r;
      endcase
    end
  end

  always_comb begin
    vld_nxt = {vld_r[LAT-2:0], accept};
    rej_nxt = {rej_r[LAT-3:0], reject};
    rnd_hi  = rnd[RND_W-1:OUT_W-1];
    if (rej_r[LAT-2]) begin
      fx_nxt = '0;
    end else if ((rnd_hi == '0) || (rnd_hi == '1)) begin
      fx_nxt = rnd[OUT_W-1:0];
    end else if (rnd[RND_W-1]) begin
      fx_nxt = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      fx_nxt = {1'b0, {(OUT_W-1){1'b1}}};
    end
    ok_nxt = !rej_r[LAT-2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
      vld_r  <= '0;
    end else begin
      coef_r <= coef_nxt;
      vld_r  <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rej_r <= rej_nxt;
    fx_r  <= fx_nxt;
    ok_r  <= ok_nxt;
  end

  bpc_scale #(.DIVISOR(PRESSURE_SCALE)) u_scale_p (
    .clk (clk),
    .raw (in_raw_pressure),
    .q   (p_q24)
  );

  bpc_scale #(.DIVISOR(TEMP_SCALE)) u_scale_t (
    .clk (clk),
    .raw (in_raw_temperature),
    .q   (t_q24)
  );

  bpc_poly u_poly (
    .clk  (clk),
    .coef (coef_r),
    .p    (p_q24),
    .t    (t_q24),
    .rnd  (rnd)
  );

  assign out_strobe      = vld_r[LAT-1];
  assign out_pressure_fx = fx_r;
  assign out_valid_res   = ok_r;

endmodule

@@ dv/bpc_checker.sv @@
// Checker that predicts the compensated pressure of each reading and compares the results.
`timescale 1ns / 100ps

module bpc_checker
  import bpc_pkg::*;
#(
  parameter int PRESSURE_SCALE = 253952,
  parameter int TEMP_SCALE     = 1572864
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    busy,
  input  logic signed [RAW_W-1:0] in_raw_pressure,
  input  logic signed [RAW_W-1:0] in_raw_temperature,
  input  logic                    out_strobe,
  input  logic signed [OUT_W-1:0] out_pressure_fx,
  input  logic                    out_valid_res,
  input  logic                    cfg_we,
  input  logic [REG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  output int                      mismatch_count,
  output int                      pending_count,
  output int                      checked_count
);

  localparam longint Q24_ONE = 64'sd1 <<< FRAC_W;

  typedef struct packed {
    logic signed [OUT_W-1:0] pressure_fx;
    logic                    valid_res;
  } reading_t;

  bpc_coef_t coefs;
  reading_t  expected_readings[$];
  reading_t  want;

  function automatic longint q24_product(input longint x, input longint y);
    logic signed [127:0] prod;
    logic [127:0]        mag;
    longint              r;
    prod = x * y;
    mag = prod[127] ? -prod : prod;
    mag = (mag + (128'd1 << (FRAC_W - 1))) >> FRAC_W;
    r = longint'(mag[62:0]);
    return prod[127] ? -r : r;
  endfunction

  function automatic longint scale_to_q24(input logic signed [RAW_W-1:0] raw,
                                          input longint unsigned divisor);
    longint          m;
    longint unsigned n;
    longint unsigned q;
    m = longint'(raw);
    if (m < 0) begin
      m = -m;
    end
    n = longint'(m) << FRAC_W;
    q = (n + divisor / 2) / divisor;
    return (raw < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic reading_t predict_reading(input logic signed [RAW_W-1:0] rp,
                                               input logic signed [RAW_W-1:0] rt,
                                               input bpc_coef_t k);
    reading_t res;
    longint   p, t, a, b, pp, tp, d, total, mag, val;
    res = '0;
    if (rp == '0 || rp == RAW_REJECT) begin
      return res;
    end
    p = scale_to_q24(rp, PRESSURE_SCALE);
    t = scale_to_q24(rt, TEMP_SCALE);
    a = longint'($signed(k.p2)) * Q24_ONE + longint'($signed(k.p3)) * p;
    b = longint'($signed(k.p1)) * Q24_ONE + q24_product(p, a);
    pp = q24_product(p, b);
    tp = q24_product(t, p);
    d = longint'($signed(k.tp1)) * Q24_ONE + longint'($signed(k.tp2)) * p;
    total = longint'($signed(k.offset)) * Q24_ONE + pp + longint'($signed(k.t1)) * t
            + q24_product(tp, d);
    mag = (total < 0) ? -total : total;
    mag = (mag + (64'sd1 <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    val = (total < 0) ? -mag : mag;
    if (val > 64'sd2147483647) begin
      val = 64'sd2147483647;
    end
    if (val < -64'sd2147483648) begin
      val = -64'sd2147483648;
    end
    res.pressure_fx = val[OUT_W-1:0];
    res.valid_res   = 1'b1;
    return res;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
  endtask

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
    checked_count  = 0;
    coefs          = '0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      coefs = '0;
      expected_readings.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_OFFSET: coefs.offset = cfg_data[CL_W-1:0];
          REG_P1:     coefs.p1     = cfg_data[CL_W-1:0];
          REG_P2:     coefs.p2     = cfg_data[CS_W-1:0];
          REG_P3:     coefs.p3     = cfg_data[CS_W-1:0];
          REG_T1:     coefs.t1     = cfg_data[CS_W-1:0];
          REG_TP1:    coefs.tp1    = cfg_data[CS_W-1:0];
          REG_TP2:    coefs.tp2    = cfg_data[CS_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        expected_readings.push_back(predict_reading(in_raw_pressure, in_raw_temperature,
                                                    coefs));
      end
      if (out_strobe) begin
        if (expected_readings.size() == 0) begin
          note_mismatch($sformatf("result with nothing expected: pressure %0d valid %0b",
                                  out_pressure_fx, out_valid_res));
        end else begin
          want = expected_readings.pop_front();
          checked_count++;
          if (out_pressure_fx !== want.pressure_fx || out_valid_res !== want.valid_res) begin
            note_mismatch($sformatf("pressure exp %0d got %0d, valid exp %0b got %0b",
                                    want.pressure_fx, out_pressure_fx,
                                    want.valid_res, out_valid_res));
          end
        end
      end
    end
    pending_count = expected_readings.size();
  end

endmodule

@@ dv/testbench.sv @@
// Testbench top that drives readings and coefficient settings into the compensation block.
`timescale 1ns / 100ps

module testbench
  import bpc_pkg::*;
();

  localparam int PRESSURE_SCALE  = 253952;
  localparam int TEMP_SCALE      = 1572864;
  localparam int ITEMS_PER_PHASE = 215;
  localparam int NUM_PHASES      = 8;
  localparam int WATCHDOG_LIMIT  = 2000;

  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef enum int {SET_TYPICAL, SET_MAX, SET_MIN, SET_EDGE, SET_SMALL, SET_RANDOM} coef_set_t;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic signed [RAW_W-1:0] in_raw_pressure;
  logic signed [RAW_W-1:0] in_raw_temperature;
  logic                    out_strobe;
  logic signed [OUT_W-1:0] out_pressure_fx;
  logic                    out_valid_res;
  logic                    cfg_we;
  logic [REG_IDX_W-1:0]    cfg_index;
  logic [CFG_W-1:0]        cfg_data;

  int mismatch_count;
  int pending_count;
  int checked_count;
  int sent_count;
  int reject_count;
  int setting_count;
  int idle_cycles;
  bit burst;

  coef_set_t phase_plan[NUM_PHASES] = '{SET_MAX, SET_MIN, SET_EDGE, SET_SMALL,
                                        SET_RANDOM, SET_RANDOM, SET_RANDOM, SET_RANDOM};

  baro_pressure_compensation #(
    .PRESSURE_SCALE(PRESSURE_SCALE),
    .TEMP_SCALE    (TEMP_SCALE)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_raw_pressure   (in_raw_pressure),
    .in_raw_temperature(in_raw_temperature),
    .out_strobe        (out_strobe),
    .out_pressure_fx   (out_pressure_fx),
    .out_valid_res     (out_valid_res),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  bpc_checker #(
    .PRESSURE_SCALE(PRESSURE_SCALE),
    .TEMP_SCALE    (TEMP_SCALE)
  ) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_raw_pressure   (in_raw_pressure),
    .in_raw_temperature(in_raw_temperature),
    .out_strobe        (out_strobe),
    .out_pressure_fx   (out_pressure_fx),
    .out_valid_res     (out_valid_res),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mismatch_count    (mismatch_count),
    .pending_count     (pending_count),
    .checked_count     (checked_count)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles", idle_cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic logic [RAW_W-1:0] pick_raw();
    int r;
    r = $urandom_range(99);
    if (r < 5) begin
      return '0;
    end else if (r < 10) begin
      return RAW_REJECT;
    end else if (r < 18) begin
      case ($urandom_range(3))
        0: return 24'h7FFFFF;
        1: return 24'h800001;
        2: return 24'h000001;
        default: return 24'hFFFFFF;
      endcase
    end else if (r < 35) begin
      return RAW_W'(longint'($urandom_range(8191)) - 4096);
    end
    return RAW_W'($urandom);
  endfunction

  function automatic int pick_gap(input bit no_idle);
    int r;
    if (no_idle) begin
      return 0;
    end
    r = $urandom_range(99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(3, 1);
    end
    return $urandom_range(40, 10);
  endfunction

  function automatic logic [CFG_W-1:0] pick_coef(input coef_set_t mode,
                                                 input logic [REG_IDX_W-1:0] idx);
    int               w;
    longint           v;
    logic [CFG_W-1:0] mask;
    logic [CFG_W-1:0] word;
    w = (idx == REG_OFFSET || idx == REG_P1) ? CL_W : CS_W;
    word = CFG_W'($urandom);
    case (mode)
      SET_MAX:   v = (64'sd1 <<< (w - 1)) - 1;
      SET_MIN:   v = -(64'sd1 <<< (w - 1));
      SET_EDGE:  v = $urandom_range(1) ? (64'sd1 <<< (w - 1)) - 1 : -(64'sd1 <<< (w - 1));
      SET_SMALL: v = longint'($urandom_range(64)) - 32;
      SET_TYPICAL: begin
        case (idx)
          REG_OFFSET: v = 150000;
          REG_P1:     v = -180000;
          REG_P2:     v = -12000;
          REG_P3:     v = 900;
          REG_T1:     v = -600;
          REG_TP1:    v = 1500;
          default:    v = -250;
        endcase
      end
      default:   v = longint'($urandom);
    endcase
    mask = CFG_W'((64'd1 << w) - 1);
    return (word & ~mask) | (CFG_W'(v) & mask);
  endfunction

  task automatic load_coefs(input coef_set_t mode);
    logic [REG_IDX_W-1:0] idx;
    for (idx = REG_OFFSET; idx <= REG_TP2; idx++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= pick_coef(mode, idx);
    end
    @(negedge clk);
    cfg_index <= REG_UNUSED;
    cfg_data  <= CFG_W'($urandom);
    @(negedge clk);
    cfg_we <= 1'b0;
    setting_count++;
  endtask

  task automatic send_reading(input logic [RAW_W-1:0] rp, input logic [RAW_W-1:0] rt,
                              input int gap);
    @(negedge clk);
    start              <= 1'b1;
    in_raw_pressure    <= rp;
    in_raw_temperature <= rt;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    sent_count++;
    if (rp == '0 || rp == RAW_REJECT) begin
      reject_count++;
    end
    if (gap > 0) begin
      @(negedge clk);
      start              <= 1'b0;
      in_raw_pressure    <= RAW_W'($urandom);
      in_raw_temperature <= RAW_W'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_count != 0) begin
      @(negedge clk);
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    start              = 1'b0;
    in_raw_pressure    = '0;
    in_raw_temperature = '0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    idle_cycles        = 0;
    sent_count         = 0;
    reject_count       = 0;
    setting_count      = 0;
    burst              = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // All coefficients still at their reset value of zero.
    send_reading(24'h7FFFFF, 24'h7FFFFF, 0);
    send_reading(RAW_REJECT, 24'h000000, 1);
    send_reading(24'hFFFFFF, 24'h800000, 0);
    send_reading(24'h000000, 24'h000001, 2);
    drain();

    load_coefs(SET_TYPICAL);
    send_reading(24'h000001, 24'h000000, 0);
    send_reading(24'hFFFFFF, 24'h000000, 0);
    send_reading(24'h7FFFFF, 24'h7FFFFF, 1);
    send_reading(24'h7FFFFF, 24'h800000, 0);
    send_reading(24'h800001, 24'h7FFFFF, 0);
    send_reading(24'h800001, 24'h800000, 3);
    send_reading(24'h000000, 24'd123456, 0);
    send_reading(RAW_REJECT, -24'sd5, 0);
    send_reading(24'd253952, 24'h000000, 1);
    send_reading(-24'sd253952, 24'd1572864, 0);
    send_reading(24'd126976, -24'sd1572864, 0);
    send_reading(24'd5000000, 24'h000001, 2);
    send_reading(-24'sd5000000, 24'hFFFFFF, 0);
    send_reading(24'h000001, 24'h7FFFFF, 0);
    send_reading(24'hFFFFFF, 24'h800000, 0);
    send_reading(24'h000000, 24'h000000, 0);
    drain();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      load_coefs(phase_plan[phase]);
      burst = (phase % 3 == 1);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(49) == 0) begin
          burst = !burst;
        end
        send_reading(pick_raw(), pick_raw(), pick_gap(burst));
      end
      drain();
    end

    repeat (LAT + 5) @(negedge clk);

    $display("Sent %0d readings (%0d with rejected raw pressure) under %0d coefficient settings.",
             sent_count, reject_count, setting_count);
    $display("Checked %0d results against the predicted pressure, %0d mismatches.",
             checked_count, mismatch_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
